>>> rtl/imu_serial_frame_decoder_assert.svh
// Assertion macros for the IMU serial frame decoder.
// Used inside modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef IMU_SERIAL_FRAME_DECODER_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_ASSERT_SVH

// Property checked on every rising edge outside reset
`define ISFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ISFD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/isfd_pkg.sv
// Package for the IMU serial frame decoder: frame constants and shared types.
// No dependencies.
package isfd_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned LONG_LEN        = 20;   // combined frame, no checksum
  localparam int unsigned SHORT_LEN       = 11;   // standard frame with sum byte
  localparam int unsigned SUM_BYTES       = 10;   // bytes covered by the checksum
  localparam int unsigned LONG_WORDS      = 9;
  localparam int unsigned SHORT_WORDS     = 4;
  localparam int unsigned FIRST_WORD_BYTE = 2;
  localparam int unsigned OUT_BYTES       = 2 * LONG_WORDS;
  localparam int unsigned IDX_W           = $clog2(LONG_LEN + 1);
  localparam int unsigned POS_W           = $clog2(SHORT_LEN);
  localparam int unsigned USER_W          = DATA_W + 1;

  localparam logic [DATA_W-1:0] HDR_BYTE   = 8'h55;
  localparam logic [DATA_W-1:0] CFG_RESET  = 8'd97;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [POS_W-1:0]  pos_t;

endpackage

>>> rtl/imu_serial_frame_decoder.sv
// IMU serial frame decoder: frame assembly in a 20-byte synchronous buffer memory.
// A good frame is delivered after a walk over its buffered words, later while an
// earlier result still waits; a failed checksum with a header inside resyncs by a
// walk that copies the bytes from that header down to the buffer start.
// Throughput: one byte per cycle while collecting; input stalls during these walks,
// set by the single read port of the buffer memory (one byte per cycle).
// Reset: asynchronous, clears control state and the type register to 97; the buffer
// memory is not cleared and only written entries are ever read.
`include "imu_serial_frame_decoder_assert.svh"

module imu_serial_frame_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: combined_type_code
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [isfd_pkg::DATA_W-1:0]       cfg_data_i,
  // received bytes; tdata: rx_byte[7:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [isfd_pkg::DATA_W-1:0]       s_axis_tdata,
  // decoded frames
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: word_0[15:0], word_1[31:16], ... word_8[143:128]
  output logic [8*isfd_pkg::OUT_BYTES-1:0]  m_axis_tdata,
  // tuser: frame_type[7:0], is_combined[8]
  output logic [isfd_pkg::USER_W-1:0]       m_axis_tuser
);

  typedef enum logic [1:0] {ST_RUN, ST_COPY, ST_EMIT} state_e;

  localparam isfd_pkg::idx_t ShortEnd  = isfd_pkg::IDX_W'(isfd_pkg::SHORT_LEN - 1);
  localparam isfd_pkg::idx_t LongEnd   = isfd_pkg::IDX_W'(isfd_pkg::LONG_LEN - 1);
  localparam isfd_pkg::idx_t SumBytes  = isfd_pkg::IDX_W'(isfd_pkg::SUM_BYTES);
  localparam isfd_pkg::idx_t FirstWord = isfd_pkg::IDX_W'(isfd_pkg::FIRST_WORD_BYTE);
  localparam isfd_pkg::idx_t ShortLast =
      isfd_pkg::IDX_W'(isfd_pkg::FIRST_WORD_BYTE + 2 * isfd_pkg::SHORT_WORDS - 1);

  // frame buffer
  isfd_pkg::byte_t mem [isfd_pkg::LONG_LEN];
  isfd_pkg::byte_t rd_data_q;

  state_e          state_q;
  isfd_pkg::idx_t  fill_q;
  isfd_pkg::byte_t sum_q, sum_d;
  isfd_pkg::pos_t  hdr_q, hdr_d;
  isfd_pkg::byte_t type_q, type_d;
  logic            long_q, long_d;
  isfd_pkg::byte_t cfg_q;

  // walk pointers, shared by resync copy and result assembly
  isfd_pkg::idx_t  rd_ptr_q, rd_end_q, wr_ptr_q, wr_end_q;
  logic            vld_q;

  logic                   m_valid_q;
  logic [isfd_pkg::USER_W-1:0] m_user_q;
  isfd_pkg::byte_t        out_bytes_q [isfd_pkg::OUT_BYTES];

  logic            take, walk_go, rd_en, wr_fire, last_walk;
  logic            mem_we;
  isfd_pkg::idx_t  mem_waddr;
  isfd_pkg::byte_t mem_wdata;
  logic            short_done, long_done, good;
  isfd_pkg::pos_t  resync_pos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_RUN);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    for (int i = 0; i < isfd_pkg::OUT_BYTES; i++) begin
      m_axis_tdata[8*i +: 8] = out_bytes_q[i];
    end
  end

  // input transaction and walk control
  assign take      = s_axis_tvalid && s_axis_tready &&
                     !(fill_q == '0 && s_axis_tdata != isfd_pkg::HDR_BYTE);
  assign walk_go   = (state_q == ST_COPY) || (state_q == ST_EMIT && !m_valid_q);
  assign rd_en     = walk_go && (rd_ptr_q <= rd_end_q);
  assign wr_fire   = walk_go && vld_q;
  assign last_walk = wr_fire && (wr_ptr_q == wr_end_q);

  // buffer write: incoming byte, or shifted byte during resync
  assign mem_we    = take || (wr_fire && state_q == ST_COPY);
  assign mem_waddr = take ? fill_q : wr_ptr_q;
  assign mem_wdata = take ? s_axis_tdata : rd_data_q;

  // running checksum, first header position and type, tracked per written byte
  always_comb begin
    sum_d  = sum_q;
    hdr_d  = hdr_q;
    type_d = type_q;
    long_d = long_q;
    if (mem_we) begin
      if (mem_waddr == '0) begin
        sum_d = mem_wdata;
        hdr_d = '0;
      end else begin
        if (mem_waddr < SumBytes) sum_d = sum_q + mem_wdata;
        if (mem_waddr <= ShortEnd && mem_wdata == isfd_pkg::HDR_BYTE && hdr_q == '0) begin
          hdr_d = isfd_pkg::POS_W'(mem_waddr);
        end
      end
      if (mem_waddr == isfd_pkg::IDX_W'(1)) begin
        type_d = mem_wdata;
        long_d = (mem_wdata == cfg_q);
      end
    end
  end

  // frame end decisions; the checksum byte is compared against bytes 0 to 9
  assign short_done = take && (fill_q == ShortEnd) && !long_q;
  assign long_done  = take && (fill_q == LongEnd) && long_q;
  assign good       = long_done || (short_done && sum_q == s_axis_tdata);
  always_comb begin
    if (hdr_q != '0)                            resync_pos = hdr_q;
    else if (s_axis_tdata == isfd_pkg::HDR_BYTE) resync_pos = isfd_pkg::POS_W'(ShortEnd);
    else                                        resync_pos = '0;
  end

  // buffer memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rd_data_q <= mem[rd_ptr_q];
  end

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      fill_q    <= '0;
      sum_q     <= '0;
      hdr_q     <= '0;
      type_q    <= '0;
      long_q    <= 1'b0;
      cfg_q     <= isfd_pkg::CFG_RESET;
      rd_ptr_q  <= '0;
      rd_end_q  <= '0;
      wr_ptr_q  <= '0;
      wr_end_q  <= '0;
      vld_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_user_q  <= '0;
      for (int i = 0; i < isfd_pkg::OUT_BYTES; i++) out_bytes_q[i] <= '0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      sum_q  <= sum_d;
      hdr_q  <= hdr_d;
      type_q <= type_d;
      long_q <= long_d;
      vld_q  <= rd_en;
      if (rd_en)   rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_fire) wr_ptr_q <= wr_ptr_q + 1'b1;

      case (state_q)
        ST_RUN: begin
          if (take) begin
            if (good) begin
              state_q  <= ST_EMIT;
              fill_q   <= '0;
              rd_ptr_q <= FirstWord;
              rd_end_q <= long_q ? LongEnd : ShortLast;
              wr_ptr_q <= '0;
              wr_end_q <= (long_q ? LongEnd : ShortLast) - FirstWord;
            end else if (short_done) begin
              fill_q <= '0;
              if (resync_pos != '0) begin
                state_q  <= ST_COPY;
                rd_ptr_q <= isfd_pkg::IDX_W'(resync_pos);
                rd_end_q <= ShortEnd;
                wr_ptr_q <= '0;
                wr_end_q <= ShortEnd - isfd_pkg::IDX_W'(resync_pos);
              end
            end else begin
              fill_q <= fill_q + 1'b1;
            end
          end
        end
        ST_COPY: begin
          if (last_walk) begin
            fill_q  <= wr_end_q + 1'b1;
            state_q <= ST_RUN;
          end
        end
        ST_EMIT: begin
          // first read of the walk: unused words of a short frame read as zero
          if (rd_en && rd_ptr_q == FirstWord) begin
            for (int i = 0; i < isfd_pkg::OUT_BYTES; i++) out_bytes_q[i] <= '0;
          end
          if (wr_fire) out_bytes_q[wr_ptr_q] <= rd_data_q;
          if (last_walk) begin
            m_valid_q <= 1'b1;
            m_user_q  <= {long_q, type_q};
            state_q   <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // checks
  `ISFD_NEVER(a_fill_range, fill_q > LongEnd, "fill count beyond combined frame length")
  `ISFD_NEVER(a_copy_overlap, mem_we && rd_en && mem_waddr == rd_ptr_q,
              "resync write hits the entry being read")
  `ISFD_ASSERT(a_valid_src, $rose(m_valid_q) |-> $past(state_q) == ST_EMIT,
               "result raised outside result assembly")
  `ISFD_ASSERT(a_walk_range, rd_en |-> rd_end_q <= LongEnd,
               "buffer read beyond its depth")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for imu_serial_frame_decoder: byte stream in, decoded frames out.
// Depends on isfd_pkg and the decoder RTL; stimulus, prediction and checks all live here.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 220;
  localparam int SETTLE_CYCLES = 40;    // longest walk follows a combined frame
  localparam int IDLE_LIMIT    = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    isfd_pkg::byte_t                  frame_type;
    logic                             is_combined;
    logic [8*isfd_pkg::OUT_BYTES-1:0] words;
  } decoded_frame_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  isfd_pkg::byte_t                  cfg_data_i = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  isfd_pkg::byte_t                  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [8*isfd_pkg::OUT_BYTES-1:0] m_axis_tdata;  // word_0 in [15:0] up to word_8 [143:128]
  logic [isfd_pkg::USER_W-1:0]      m_axis_tuser;  // frame_type [7:0], is_combined [8]

  // stimulus and predicted frames
  isfd_pkg::byte_t rx_bytes_q[$];
  decoded_frame_t  decoded_frames_q[$];

  // decoder state mirror
  isfd_pkg::byte_t frame_buf[isfd_pkg::LONG_LEN];
  int              fill_cnt   = 0;
  int              frame_len  = 0;
  isfd_pkg::byte_t type_code  = isfd_pkg::CFG_RESET;

  int          err_cnt    = 0;
  int          burst_left = 0;
  int          idle_left  = 0;
  int          idle_cycles = 0;
  int unsigned stall_cyc  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  imu_serial_frame_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one byte to the stimulus queue
  task automatic add_rx_byte(input isfd_pkg::byte_t b);
    rx_bytes_q.insert(rx_bytes_q.size(), b);
  endtask

  function automatic int length_for(input isfd_pkg::byte_t ftype);
    return (ftype == type_code) ? int'(isfd_pkg::LONG_LEN) : int'(isfd_pkg::SHORT_LEN);
  endfunction

  // Advance the frame mirror by one received byte; queue a frame when one completes
  task automatic decode_rx_byte(input isfd_pkg::byte_t b);
    isfd_pkg::byte_t sum;
    int              k;
    int              n;
    decoded_frame_t  res;
    // hunting for a header
    if (fill_cnt == 0 && b != isfd_pkg::HDR_BYTE) return;
    if (fill_cnt >= isfd_pkg::LONG_LEN) begin
      fill_cnt  = 0;
      frame_len = 0;
    end
    frame_buf[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt == 2) frame_len = length_for(frame_buf[1]);
    if (frame_len == 0 || fill_cnt < frame_len) return;

    // short frame: sum check, resync on failure
    if (frame_len != isfd_pkg::LONG_LEN) begin
      sum = '0;
      for (int i = 0; i < isfd_pkg::SUM_BYTES; i++) sum = sum + frame_buf[i];
      if (sum != frame_buf[isfd_pkg::SUM_BYTES]) begin
        k = 0;
        for (int i = 1; i < isfd_pkg::SHORT_LEN; i++) begin
          if (k == 0 && frame_buf[i] == isfd_pkg::HDR_BYTE) k = i;
        end
        if (k == 0) begin
          fill_cnt  = 0;
          frame_len = 0;
        end else begin
          n = int'(isfd_pkg::SHORT_LEN) - k;
          for (int i = 0; i < n; i++) frame_buf[i] = frame_buf[i + k];
          fill_cnt  = n;
          frame_len = (n >= 2) ? length_for(frame_buf[1]) : 0;
        end
        return;
      end
    end

    // good frame
    res.frame_type  = frame_buf[1];
    res.is_combined = (frame_len == isfd_pkg::LONG_LEN);
    res.words       = '0;
    for (int i = 0; i < isfd_pkg::LONG_WORDS; i++) begin
      if (res.is_combined || i < isfd_pkg::SHORT_WORDS)
        res.words[16*i +: 16] = {frame_buf[3 + 2*i], frame_buf[2 + 2*i]};
    end
    decoded_frames_q.insert(decoded_frames_q.size(), res);
    fill_cnt  = 0;
    frame_len = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Word values leaning toward the signed extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // 11-byte frame; a corrupted one gets a wrong sum and may carry stray headers
  task automatic push_short_frame(input isfd_pkg::byte_t ftype, input bit corrupt);
    isfd_pkg::byte_t fb[isfd_pkg::SHORT_LEN];
    isfd_pkg::byte_t sum;
    logic [15:0]     w;
    int              nh;
    fb[0] = isfd_pkg::HDR_BYTE;
    fb[1] = ftype;
    for (int i = 0; i < isfd_pkg::SHORT_WORDS; i++) begin
      w           = pick_word();
      fb[2 + 2*i] = w[7:0];
      fb[3 + 2*i] = w[15:8];
    end
    if (corrupt) begin
      nh = $urandom_range(0, 2);
      for (int i = 0; i < nh; i++)
        fb[$urandom_range(1, isfd_pkg::SUM_BYTES - 1)] = isfd_pkg::HDR_BYTE;
    end
    sum = '0;
    for (int i = 0; i < isfd_pkg::SUM_BYTES; i++) sum = sum + fb[i];
    fb[isfd_pkg::SUM_BYTES] = sum;
    if (corrupt) begin
      fb[isfd_pkg::SUM_BYTES] = sum + 8'($urandom_range(1, 255));
      // header in the sum byte leaves a one-byte remainder
      if (sum != isfd_pkg::HDR_BYTE && $urandom_range(0, 5) == 0)
        fb[isfd_pkg::SUM_BYTES] = isfd_pkg::HDR_BYTE;
    end
    foreach (fb[i]) add_rx_byte(fb[i]);
  endtask

  // 20-byte combined frame under the current type code
  task automatic push_combined_frame();
    logic [15:0] w;
    add_rx_byte(isfd_pkg::HDR_BYTE);
    add_rx_byte(type_code);
    for (int i = 0; i < isfd_pkg::LONG_WORDS; i++) begin
      w = pick_word();
      add_rx_byte(w[7:0]);
      add_rx_byte(w[15:8]);
    end
  endtask

  // Wait until every byte is taken and every frame delivered, then let the block settle
  task automatic drain_and_settle();
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || decoded_frames_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Byte driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes_q.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor and receiver stall pattern
  always @(posedge clk_i) begin
    decoded_frame_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_frames_q.size() == 0) begin
          report_mismatch("frame with none expected, tuser", 16'h0, 16'(m_axis_tuser));
        end else begin
          want = decoded_frames_q.pop_front();
          if (want.frame_type != m_axis_tuser[7:0])
            report_mismatch("frame_type", 16'(want.frame_type), 16'(m_axis_tuser[7:0]));
          if (want.is_combined != m_axis_tuser[8])
            report_mismatch("is_combined", 16'(want.is_combined), 16'(m_axis_tuser[8]));
          for (int i = 0; i < isfd_pkg::LONG_WORDS; i++) begin
            if (want.words[16*i +: 16] != m_axis_tdata[16*i +: 16])
              report_mismatch($sformatf("word_%0d", i), want.words[16*i +: 16],
                              m_axis_tdata[16*i +: 16]);
          end
        end
      end
      // stall style is drawn anew whenever the low nine bits of the cycle counter are zero
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc[8:0] == 9'd0) stall_mode <= stall_mode_e'($urandom_range(0, 2));
      case (stall_mode)
        STALL_NONE:   m_axis_tready <= 1'b1;
        STALL_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:      m_axis_tready <= ((stall_cyc % 7) < 3);
      endcase
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("imu_serial_frame_decoder test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed opening, then phases of random traffic under several type codes
  initial begin
    isfd_pkg::byte_t phase_codes[NUM_PHASES];
    isfd_pkg::byte_t directed_bytes[24];
    isfd_pkg::byte_t ftype;
    int              kind;
    int              n;
    int              produced;

    phase_codes = '{isfd_pkg::CFG_RESET, 8'h00, 8'hFF, isfd_pkg::HDR_BYTE, 8'($urandom),
                    8'($urandom), isfd_pkg::CFG_RESET, 8'h01};
    // two dropped bytes while hunting, a good frame of word extremes,
    // then a bad-sum frame with a header inside that forces a resync
    directed_bytes = '{8'h00, 8'hFF,
                       8'h55, 8'h51, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                       8'h00, 8'h00, 8'hA2,
                       8'h55, 8'h52, 8'h01, 8'h02, 8'h55, 8'h03, 8'h04, 8'h05,
                       8'h06, 8'h07, 8'h00};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_and_settle();
        @(posedge clk_i);
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= phase_codes[ph];
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
        type_code = phase_codes[ph];
      end
      @(negedge clk_i);
      if (ph == 0) begin
        foreach (directed_bytes[i]) add_rx_byte(directed_bytes[i]);
      end

      produced = 0;
      while (produced < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          do ftype = 8'($urandom); while (ftype == type_code);
          push_short_frame(ftype, 1'b0);
          produced += isfd_pkg::SHORT_LEN;
        end else if (kind < 65) begin
          push_combined_frame();
          produced += isfd_pkg::LONG_LEN;
        end else if (kind < 80) begin
          push_short_frame(8'($urandom), 1'b1);
          produced += isfd_pkg::SHORT_LEN;
        end else if (kind < 90) begin
          // truncated frame: header and a few bytes
          n = $urandom_range(0, 9);
          add_rx_byte(isfd_pkg::HDR_BYTE);
          for (int i = 0; i < n; i++) add_rx_byte(8'($urandom));
          produced += n + 1;
        end else begin
          // line noise
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_rx_byte(8'($urandom));
          produced += n;
        end
      end
    end

    drain_and_settle();
    if (err_cnt == 0) begin
      $display("imu_serial_frame_decoder test passed");
    end else begin
      $display("imu_serial_frame_decoder test failed");
    end
    $finish;
  end

endmodule
